### src/cau_pkg.sv
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PW         = 2 * DATA_WIDTH;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_MAG  = 3'd5;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] val;
    logic                  sat;
  } satv_t;

  // One item as it travels down the row of cells.
  typedef struct packed {
    logic [2:0]            op;
    logic                  dz;
    logic                  re_neg;
    logic                  im_neg;
    logic                  re_ovf;
    logic                  im_ovf;
    logic [PW-1:0]         d;
    logic [PW-1:0]         re_rem;
    logic [PW-1:0]         im_rem;
    logic [DATA_WIDTH-1:0] re_low;
    logic [DATA_WIDTH-1:0] im_low;
    logic [DATA_WIDTH-1:0] re_q;
    logic [DATA_WIDTH-1:0] im_q;
    logic [DATA_WIDTH+1:0] sq_rem;
    logic [DATA_WIDTH-1:0] sq_root;
    logic [PW-1:0]         sq_src;
    logic [DATA_WIDTH-1:0] fix_re;
    logic [DATA_WIDTH-1:0] fix_im;
    logic                  fix_sat;
  } cell_t;

  // Clamp a sign/magnitude value to the signed DATA_WIDTH range.
  function automatic satv_t sat_conv(input logic neg, input logic [PW:0] mag);
    logic [PW:0] lim;
    logic [PW:0] m;
    satv_t       r;
    lim = neg ? ((PW+1)'(1) << (DATA_WIDTH-1)) : (((PW+1)'(1) << (DATA_WIDTH-1)) - 1'b1);
    r.sat = (mag > lim);
    m = r.sat ? lim : mag;
    r.val = neg ? (DATA_WIDTH'(0) - m[DATA_WIDTH-1:0]) : m[DATA_WIDTH-1:0];
    return r;
  endfunction

endpackage

### src/cau_front.sv
module cau_front
  import cau_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         v_i,
  input  logic [2:0]                   op_i,
  input  logic signed [DATA_WIDTH-1:0] ar_i,
  input  logic signed [DATA_WIDTH-1:0] ai_i,
  input  logic signed [DATA_WIDTH-1:0] br_i,
  input  logic signed [DATA_WIDTH-1:0] bi_i,
  output logic                         v_o,
  output cell_t                        c_o
);

  localparam int W = DATA_WIDTH;
  localparam int F = FRAC_BITS;

  // stage A: products
  logic                 va_r;
  logic [2:0]           op_a_r;
  logic signed [W-1:0]  ar_r, ai_r, br_r, bi_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [W-1:0]  x4, x5;

  assign x4 = (op_i == OP_DIV) ? br_i : ar_i;
  assign x5 = (op_i == OP_DIV) ? bi_i : ai_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a_r <= op_i;
      ar_r   <= ar_i;
      ai_r   <= ai_i;
      br_r   <= br_i;
      bi_r   <= bi_i;
      p0_r   <= ar_i * br_i;
      p1_r   <= ai_i * bi_i;
      p2_r   <= ar_i * bi_i;
      p3_r   <= ai_i * br_i;
      p4_r   <= x4 * x4;
      p5_r   <= x5 * x5;
    end
  end

  // stage B: sums
  logic                 vb_r;
  logic [2:0]           op_b_r;
  logic signed [PW+1:0] sre_r, sim_r, sre_nxt, sim_nxt;
  logic [PW-1:0]        d_r;
  logic signed [W:0]    are_r, aim_r, are_nxt, aim_nxt;

  always_comb begin
    sre_nxt = '0;
    sim_nxt = '0;
    are_nxt = '0;
    aim_nxt = '0;
    case (op_a_r)
      OP_MUL: begin
        sre_nxt = (PW+2)'(p0_r) - (PW+2)'(p1_r);
        sim_nxt = (PW+2)'(p2_r) + (PW+2)'(p3_r);
      end
      OP_DIV: begin
        sre_nxt = (PW+2)'(p0_r) + (PW+2)'(p1_r);
        sim_nxt = (PW+2)'(p3_r) - (PW+2)'(p2_r);
      end
      OP_ADD: begin
        are_nxt = (W+1)'(ar_r) + (W+1)'(br_r);
        aim_nxt = (W+1)'(ai_r) + (W+1)'(bi_r);
      end
      OP_SUB: begin
        are_nxt = (W+1)'(ar_r) - (W+1)'(br_r);
        aim_nxt = (W+1)'(ai_r) - (W+1)'(bi_r);
      end
      OP_CONJ: begin
        are_nxt = (W+1)'(ar_r);
        aim_nxt = -((W+1)'(ai_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_b_r <= op_a_r;
      sre_r  <= sre_nxt;
      sim_r  <= sim_nxt;
      are_r  <= are_nxt;
      aim_r  <= aim_nxt;
      d_r    <= $unsigned(p4_r) + $unsigned(p5_r);
    end
  end

  // stage C: magnitudes, overflow check, saturation of the simple ops
  logic signed [PW+1:0] sre_abs, sim_abs;
  logic [PW-1:0]        n_re, n_im;
  logic [W:0]           are_abs, aim_abs;
  satv_t                mre, mim, fre, fim;
  cell_t                c_nxt;
  logic                 vc_r;
  cell_t                c_r;

  always_comb begin
    sre_abs = sre_r[PW+1] ? -sre_r : sre_r;
    sim_abs = sim_r[PW+1] ? -sim_r : sim_r;
    n_re    = sre_abs[PW-1:0];
    n_im    = sim_abs[PW-1:0];
    are_abs = are_r[W] ? (W+1)'(0) - are_r : are_r;
    aim_abs = aim_r[W] ? (W+1)'(0) - aim_r : aim_r;
    mre = sat_conv(sre_r[PW+1], sre_abs[PW:0] >> F);
    mim = sat_conv(sim_r[PW+1], sim_abs[PW:0] >> F);
    fre = sat_conv(are_r[W], (PW+1)'(are_abs));
    fim = sat_conv(aim_r[W], (PW+1)'(aim_abs));

    c_nxt         = '0;
    c_nxt.op      = op_b_r;
    c_nxt.dz      = (op_b_r == OP_DIV) && (d_r == '0);
    c_nxt.re_neg  = sre_r[PW+1];
    c_nxt.im_neg  = sim_r[PW+1];
    c_nxt.re_ovf  = ((2*PW)'(n_re) << W) >= ((2*PW)'(d_r) << (2*W-F));
    c_nxt.im_ovf  = ((2*PW)'(n_im) << W) >= ((2*PW)'(d_r) << (2*W-F));
    c_nxt.d       = d_r;
    c_nxt.re_rem  = n_re >> (W-F);
    c_nxt.im_rem  = n_im >> (W-F);
    c_nxt.re_low  = W'(n_re << F);
    c_nxt.im_low  = W'(n_im << F);
    c_nxt.sq_src  = d_r;
    case (op_b_r)
      OP_MUL: begin
        c_nxt.fix_re  = mre.val;
        c_nxt.fix_im  = mim.val;
        c_nxt.fix_sat = mre.sat | mim.sat;
      end
      OP_ADD, OP_SUB, OP_CONJ: begin
        c_nxt.fix_re  = fre.val;
        c_nxt.fix_im  = fim.val;
        c_nxt.fix_sat = fre.sat | fim.sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign v_o = vc_r;
  assign c_o = c_r;

endmodule

### src/cau_cell.sv
module cau_cell
  import cau_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  v_i,
  input  cell_t c_i,
  output logic  v_o,
  output cell_t c_o
);

  localparam int W = DATA_WIDTH;

  logic          v_r;
  cell_t         c_r, c_nxt;
  logic [PW:0]   sh_re, sh_im;
  logic [W+1:0]  sq_sh, sq_try;

  always_comb begin
    c_nxt = c_i;
    // one restoring division step per lane
    sh_re = {c_i.re_rem, c_i.re_low[W-1]};
    sh_im = {c_i.im_rem, c_i.im_low[W-1]};
    c_nxt.re_low = c_i.re_low << 1;
    c_nxt.im_low = c_i.im_low << 1;
    if (sh_re >= {1'b0, c_i.d}) begin
      c_nxt.re_rem = PW'(sh_re - {1'b0, c_i.d});
      c_nxt.re_q   = {c_i.re_q[W-2:0], 1'b1};
    end else begin
      c_nxt.re_rem = sh_re[PW-1:0];
      c_nxt.re_q   = {c_i.re_q[W-2:0], 1'b0};
    end
    if (sh_im >= {1'b0, c_i.d}) begin
      c_nxt.im_rem = PW'(sh_im - {1'b0, c_i.d});
      c_nxt.im_q   = {c_i.im_q[W-2:0], 1'b1};
    end else begin
      c_nxt.im_rem = sh_im[PW-1:0];
      c_nxt.im_q   = {c_i.im_q[W-2:0], 1'b0};
    end
    // one root digit: bring down two radicand bits
    sq_sh  = {c_i.sq_rem[W-1:0], c_i.sq_src[PW-1:PW-2]};
    sq_try = {c_i.sq_root, 2'b01};
    c_nxt.sq_src = c_i.sq_src << 2;
    if (sq_sh >= sq_try) begin
      c_nxt.sq_rem  = sq_sh - sq_try;
      c_nxt.sq_root = {c_i.sq_root[W-2:0], 1'b1};
    end else begin
      c_nxt.sq_rem  = sq_sh;
      c_nxt.sq_root = {c_i.sq_root[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign v_o = v_r;
  assign c_o = c_r;

endmodule

### src/cau_back.sv
module cau_back
  import cau_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         v_i,
  input  cell_t                        c_i,
  output logic                         v_o,
  output logic signed [DATA_WIDTH-1:0] re_o,
  output logic signed [DATA_WIDTH-1:0] im_o,
  output logic [1:0]                   st_o
);

  localparam int W = DATA_WIDTH;

  logic                v_r;
  logic signed [W-1:0] re_r, im_r, re_nxt, im_nxt;
  logic [1:0]          st_r, st_nxt;
  satv_t               qre, qim, rt;
  logic                sat;

  always_comb begin
    qre = sat_conv(c_i.re_neg, c_i.re_ovf ? '1 : (PW+1)'(c_i.re_q));
    qim = sat_conv(c_i.im_neg, c_i.im_ovf ? '1 : (PW+1)'(c_i.im_q));
    rt  = sat_conv(1'b0, (PW+1)'(c_i.sq_root));
    re_nxt = '0;
    im_nxt = '0;
    sat    = 1'b0;
    st_nxt = ST_OK;
    unique case (c_i.op)
      OP_ADD, OP_SUB, OP_MUL, OP_CONJ: begin
        re_nxt = c_i.fix_re;
        im_nxt = c_i.fix_im;
        sat    = c_i.fix_sat;
      end
      OP_DIV: begin
        if (!c_i.dz) begin
          re_nxt = qre.val;
          im_nxt = qim.val;
          sat    = qre.sat | qim.sat;
        end
      end
      OP_MAG: begin
        re_nxt = rt.val;
        sat    = rt.sat;
      end
      default: ;
    endcase
    if (c_i.dz) begin
      st_nxt = ST_DZ;
    end else if (sat) begin
      st_nxt = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      st_r <= st_nxt;
    end
  end

  assign v_o  = v_r;
  assign re_o = re_r;
  assign im_o = im_r;
  assign st_o = st_r;

endmodule

### src/complex_arithmetic_unit.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------
// input    | in_valid / in_ready | in_operation, in_a_real/imag, in_b_real/imag
// result   | out_valid/out_ready | out_res_real, out_res_imag, out_status
//
// One item enters per cycle unless the pipeline is stalled; each result passes
// through three front stages (products, sums, scaling), one cell per
// quotient/root bit, and the output register.
// Reset (rst_n low, synchronous) empties the pipeline; items in flight are dropped.
// A held result stalls the whole pipeline; in_ready drops only then.
module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_operation,
  input  logic signed [DATA_WIDTH-1:0] in_a_real,
  input  logic signed [DATA_WIDTH-1:0] in_a_imag,
  input  logic signed [DATA_WIDTH-1:0] in_b_real,
  input  logic signed [DATA_WIDTH-1:0] in_b_imag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_res_real,
  output logic signed [DATA_WIDTH-1:0] out_res_imag,
  output logic [1:0]                   out_status
);

  localparam int N = DATA_WIDTH;

  logic  en;
  logic  v   [0:N];
  cell_t c   [0:N];

  // advance everything unless a finished result is waiting
  assign en       = out_ready | ~out_valid;
  assign in_ready = en;

  cau_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (in_valid & in_ready),
    .op_i  (in_operation),
    .ar_i  (in_a_real),
    .ai_i  (in_a_imag),
    .br_i  (in_b_real),
    .bi_i  (in_b_imag),
    .v_o   (v[0]),
    .c_o   (c[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    cau_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .v_i   (v[i]),
      .c_i   (c[i]),
      .v_o   (v[i+1]),
      .c_o   (c[i+1])
    );
  end

  cau_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (v[N]),
    .c_i   (c[N]),
    .v_o   (out_valid),
    .re_o  (out_res_real),
    .im_o  (out_res_imag),
    .st_o  (out_status)
  );

endmodule

### sim/complex_arithmetic_unit_tb.sv
module complex_arithmetic_unit_tb
  import cau_pkg::*;
();

  typedef logic signed [199:0] wide_t;
  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef struct {
    logic [2:0] op;
    word_t      ar, ai, br, bi;
  } operands_t;

  typedef struct {
    word_t      re, im;
    logic [1:0] st;
  } cplx_result_t;

  class cplx_scoreboard;
    cplx_result_t pending_q[$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    // Clamp an exact value to the word range.
    function word_t clamp(wide_t v, inout bit sat);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
      lo = -(wide_t'(1) <<< (DATA_WIDTH - 1));
      if (v > hi) begin
        sat = 1;
        return word_t'(hi);
      end
      if (v < lo) begin
        sat = 1;
        return word_t'(lo);
      end
      return word_t'(v);
    endfunction

    function logic [127:0] int_root(logic [127:0] s);
      logic [127:0] root, bitv;
      root = 0;
      bitv = 128'd1 << 126;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (s >= root + bitv) begin
          s = s - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function void note_input(operands_t x);
      wide_t ar, ai, br, bi, re, im, den, scale;
      bit sat;
      cplx_result_t r;
      ar = x.ar; ai = x.ai; br = x.br; bi = x.bi;
      scale = wide_t'(1) <<< FRAC_BITS;
      re = 0; im = 0; sat = 0;
      r.st = ST_OK;
      case (x.op)
        OP_ADD: begin
          re = ar + br; im = ai + bi;
        end
        OP_SUB: begin
          re = ar - br; im = ai - bi;
        end
        OP_MUL: begin
          re = (ar * br - ai * bi) / scale;
          im = (ar * bi + ai * br) / scale;
        end
        OP_DIV: begin
          den = br * br + bi * bi;
          if (den == 0) begin
            r.st = ST_DZ;
          end else begin
            re = ((ar * br + ai * bi) * scale) / den;
            im = ((ai * br - ar * bi) * scale) / den;
          end
        end
        OP_CONJ: begin
          re = ar; im = -ai;
        end
        OP_MAG: re = wide_t'({72'd0, int_root(128'(ar * ar + ai * ai))});
        default: ;
      endcase
      r.re = clamp(re, sat);
      r.im = clamp(im, sat);
      if (r.st == ST_OK && sat) r.st = ST_SAT;
      pending_q.push_back(r);
    endfunction

    function void check_result(word_t re, word_t im, logic [1:0] st);
      cplx_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result re=%0d im=%0d status=%0d", re, im, st);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (re !== e.re) begin
        $error("res_real: expected %0d, actual %0d", e.re, re);
        errors++;
      end
      if (im !== e.im) begin
        $error("res_imag: expected %0d, actual %0d", e.im, im);
        errors++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, actual %0d", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_ready;
  logic [2:0] in_operation = 0;
  word_t      in_a_real = 0, in_a_imag = 0, in_b_real = 0, in_b_imag = 0;
  logic       out_valid;
  logic       out_ready = 0;
  word_t      out_res_real, out_res_imag;
  logic [1:0] out_status;

  cplx_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_request = 0;
  int  cycle_count = 0;

  localparam word_t WMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  complex_arithmetic_unit uut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: check transfers, stall at random, hold off on request.
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_res_real, out_res_imag, out_status);
    if (hold_request && hold_left == 0) begin
      hold_left = 400;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(operands_t x);
    in_valid <= 1;
    in_operation <= x.op;
    in_a_real <= x.ar; in_a_imag <= x.ai;
    in_b_real <= x.br; in_b_imag <= x.bi;
    do @(posedge clk); while (!in_ready);
    sb.note_input(x);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(5))
      0: return word_t'($urandom);
      1: return word_t'($urandom);
      2: return word_t'($signed($urandom_range(8 << FRAC_BITS)) - (4 << FRAC_BITS));
      3: case ($urandom_range(4))
           0: return 0;
           1: return 1;
           2: return -1;
           3: return WMAX;
           default: return WMIN;
         endcase
      4: return word_t'($signed($urandom_range(2000)) - 1000);
      default: return word_t'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  task automatic send_random(int n);
    operands_t x;
    repeat (n) begin
      x.op = 3'($urandom_range(7));
      x.ar = pick_word(); x.ai = pick_word();
      x.br = pick_word(); x.bi = pick_word();
      if ($urandom_range(49) == 0) begin
        x.br = 0;
        x.bi = 0;
      end
      send_item(x);
    end
  endtask

  initial begin
    operands_t d[$];
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    d.push_back('{OP_ADD, WMAX, WMIN, WMAX, WMIN});
    d.push_back('{OP_ADD, 32'sd65536, -32'sd3, 32'sd7, 32'sd5});
    d.push_back('{OP_SUB, WMIN, WMAX, 32'sd1, -32'sd1});
    d.push_back('{OP_SUB, 32'sd100, 32'sd0, -32'sd200, 32'sd50});
    d.push_back('{OP_MUL, WMAX, WMAX, WMAX, WMIN});
    d.push_back('{OP_MUL, WMIN, WMIN, WMIN, WMIN});
    d.push_back('{OP_MUL, -32'sd3, 32'sd1, 32'sd1, 32'sd0});
    d.push_back('{OP_MUL, 32'sd131072, -32'sd65536, 32'sd98304, 32'sd32768});
    d.push_back('{OP_DIV, 32'sd65536, 32'sd0, 32'sd0, 32'sd0});
    d.push_back('{OP_DIV, WMAX, WMIN, 32'sd0, 32'sd0});
    d.push_back('{OP_DIV, 32'sd65536, 32'sd65536, 32'sd131072, -32'sd65536});
    d.push_back('{OP_DIV, WMAX, WMAX, 32'sd1, 32'sd0});
    d.push_back('{OP_DIV, WMIN, WMIN, WMIN, WMIN});
    d.push_back('{OP_DIV, -32'sd1, 32'sd0, WMAX, 32'sd0});
    d.push_back('{OP_CONJ, WMIN, WMIN, 32'sd0, 32'sd0});
    d.push_back('{OP_CONJ, WMAX, 32'sd0, 32'sd5, 32'sd5});
    d.push_back('{OP_CONJ, -32'sd7, WMAX, 32'sd0, 32'sd0});
    d.push_back('{OP_MAG, WMIN, WMIN, 32'sd0, 32'sd0});
    d.push_back('{OP_MAG, WMAX, 32'sd0, 32'sd0, 32'sd0});
    d.push_back('{OP_MAG, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    d.push_back('{OP_MAG, 32'sd3, -32'sd4, 32'sd0, 32'sd0});
    d.push_back('{3'd6, WMAX, WMIN, 32'sd1, 32'sd1});
    d.push_back('{3'd7, -32'sd1, -32'sd1, -32'sd1, -32'sd1});
    foreach (d[i]) send_item(d[i]);

    send_random(250);
    send_idle_pct = 69;
    send_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    send_random(200);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    send_random(250);
    // Long receiver hold-off while items keep coming, so the pipe fills.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1;
    send_random(250);

    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/cau_pkg.sv
src/cau_front.sv
src/cau_cell.sv
src/cau_back.sv
src/complex_arithmetic_unit.sv
sim/complex_arithmetic_unit_tb.sv
